// File: hdl/tcei_pkg.sv
// Shared types and constants for the text console escape interpreter.
// No dependencies; used by tcei_core and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tcei_pkg;

    // control bytes and escape letters
    localparam logic [7:0] CH_ESC     = 8'd27;
    localparam logic [7:0] CH_BS      = 8'd8;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] LT_POS     = 8'h40;  // '@'
    localparam logic [7:0] LT_ATTR    = 8'h41;  // 'A'
    localparam logic [7:0] LT_FLASH   = 8'h42;  // 'B'
    localparam logic [7:0] LT_CLEAR   = 8'h43;  // 'C'
    localparam logic [7:0] LT_ERASE   = 8'h45;  // 'E'
    localparam logic [7:0] LT_RIGHT   = 8'h52;  // 'R'
    localparam logic [7:0] LT_UP      = 8'h55;  // 'U'
    localparam logic [7:0] LT_XOR     = 8'h58;  // 'X'

    localparam logic [7:0] ATTR_RESET = 8'd7;   // light grey on black
    localparam logic [7:0] COLS_RESET = 8'd80;

    // APB register map
    localparam int unsigned PADDR_W   = 3;
    localparam logic        REG_COLS  = 1'b0;   // paddr[2] selects the register

    typedef enum logic [0:0] {
        KIND_BYTE  = 1'b0,
        KIND_FLUSH = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        CMD_PUT    = 3'd0,
        CMD_CLEAR  = 3'd1,
        CMD_ERASE  = 3'd2,
        CMD_FLASH  = 3'd3,
        CMD_CURSOR = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ESC     = 3'd1,
        PH_POS_ROW = 3'd2,
        PH_POS_COL = 3'd3,
        PH_ATTR    = 3'd4,
        PH_FLASH   = 3'd5,
        PH_XOR     = 3'd6
    } t_phase;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] column;
        logic [7:0] row;
        logic [7:0] attribute;
        logic [7:0] value;
        logic [7:0] end_column;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/tcei_if.sv
// Valid/ready channel interfaces: console byte words in, screen command words out.
// Depends on nothing but the handshake convention (accept on valid && ready).
`timescale 1ns / 1ps
`default_nettype none

interface tcei_byte_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data;

    modport source (output valid, output kind, output data, input ready);
    modport sink   (input valid, input kind, input data, output ready);
endinterface

interface tcei_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] attribute;
    logic [7:0] value;
    logic [7:0] end_column;

    modport source (output valid, output command, output column, output row,
                    output attribute, output value, output end_column, input ready);
    modport sink   (input valid, input command, input column, input row,
                    input attribute, input value, input end_column, output ready);
endinterface

`default_nettype wire

// File: hdl/tcei_core.sv
// Escape parser and cursor/attribute state; one word per accepted cycle.
// Depends on tcei_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcei_core (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_accept,
    input  wire               i_kind,
    input  wire  [7:0]        i_data,
    input  wire  [7:0]        i_screen_columns,
    output logic              o_res_valid,
    output tcei_pkg::t_result o_res
);

    tcei_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_col, n_col;
    logic [7:0]       r_row, n_row;
    logic [7:0]       r_attr, n_attr;
    logic [7:0]       w_endc;
    logic             w_is_flush;

    assign w_is_flush = (i_kind == tcei_pkg::KIND_FLUSH);
    // zero columns behaves as one
    assign w_endc = (i_screen_columns == 8'd0) ? 8'd0 : i_screen_columns - 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tcei_pkg::PH_IDLE;
            r_col   <= 8'd0;
            r_row   <= 8'd0;
            r_attr  <= tcei_pkg::ATTR_RESET;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_col   <= n_col;
            r_row   <= n_row;
            r_attr  <= n_attr;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_col   = r_col;
        n_row   = r_row;
        n_attr  = r_attr;
        if (!w_is_flush) begin
            unique case (r_phase)
                tcei_pkg::PH_ESC: begin
                    n_phase = tcei_pkg::PH_IDLE;
                    case (i_data)
                        tcei_pkg::LT_POS:   n_phase = tcei_pkg::PH_POS_ROW;
                        tcei_pkg::LT_ATTR:  n_phase = tcei_pkg::PH_ATTR;
                        tcei_pkg::LT_FLASH: n_phase = tcei_pkg::PH_FLASH;
                        tcei_pkg::LT_XOR:   n_phase = tcei_pkg::PH_XOR;
                        tcei_pkg::LT_CLEAR: begin
                            n_col = 8'd0;
                            n_row = 8'd0;
                        end
                        tcei_pkg::LT_RIGHT: n_col = r_col + 8'd1;
                        tcei_pkg::LT_UP:    n_row = r_row - 8'd1;
                        default: ;
                    endcase
                end
                tcei_pkg::PH_POS_ROW: begin
                    n_row   = i_data;
                    n_phase = tcei_pkg::PH_POS_COL;
                end
                tcei_pkg::PH_POS_COL: begin
                    n_col   = i_data;
                    n_phase = tcei_pkg::PH_IDLE;
                end
                tcei_pkg::PH_ATTR: begin
                    n_attr  = i_data;
                    n_phase = tcei_pkg::PH_IDLE;
                end
                tcei_pkg::PH_FLASH: n_phase = tcei_pkg::PH_IDLE;
                tcei_pkg::PH_XOR: begin
                    n_attr  = r_attr ^ i_data;
                    n_phase = tcei_pkg::PH_IDLE;
                end
                default: begin
                    n_phase = tcei_pkg::PH_IDLE;
                    case (i_data)
                        tcei_pkg::CH_ESC: n_phase = tcei_pkg::PH_ESC;
                        tcei_pkg::CH_BS:  n_col = r_col - 8'd1;
                        tcei_pkg::CH_CR:  n_col = 8'd0;
                        tcei_pkg::CH_LF:  n_row = r_row + 8'd1;
                        default:          n_col = r_col + 8'd1;
                    endcase
                end
            endcase
        end
    end

    // result word
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        if (w_is_flush) begin
            o_res_valid   = 1'b1;
            o_res.command = tcei_pkg::CMD_CURSOR;
            o_res.column  = r_col;
            o_res.row     = r_row;
        end else begin
            unique case (r_phase)
                tcei_pkg::PH_ESC: begin
                    if (i_data == tcei_pkg::LT_CLEAR) begin
                        o_res_valid   = 1'b1;
                        o_res.command = tcei_pkg::CMD_CLEAR;
                    end else if (i_data == tcei_pkg::LT_ERASE && r_col <= w_endc) begin
                        o_res_valid      = 1'b1;
                        o_res.command    = tcei_pkg::CMD_ERASE;
                        o_res.column     = r_col;
                        o_res.row        = r_row;
                        o_res.attribute  = r_attr;
                        o_res.end_column = w_endc;
                    end
                end
                tcei_pkg::PH_FLASH: begin
                    o_res_valid   = 1'b1;
                    o_res.command = tcei_pkg::CMD_FLASH;
                    o_res.value   = i_data;
                end
                tcei_pkg::PH_POS_ROW, tcei_pkg::PH_POS_COL,
                tcei_pkg::PH_ATTR, tcei_pkg::PH_XOR: ;
                default: begin
                    if (i_data != tcei_pkg::CH_ESC && i_data != tcei_pkg::CH_BS &&
                        i_data != tcei_pkg::CH_CR && i_data != tcei_pkg::CH_LF) begin
                        o_res_valid     = 1'b1;
                        o_res.command   = tcei_pkg::CMD_PUT;
                        o_res.column    = r_col;
                        o_res.row       = r_row;
                        o_res.attribute = r_attr;
                        o_res.value     = i_data;
                    end
                end
            endcase
        end
    end

    // end of flush leaves the parser where it was
    a_flush_keeps_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && w_is_flush |=> $stable(r_phase) && $stable(r_col) && $stable(r_row))
        else $error("flush word changed parser state");

    a_esc_enters_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !w_is_flush && r_phase == tcei_pkg::PH_IDLE &&
        i_data == tcei_pkg::CH_ESC |=> r_phase == tcei_pkg::PH_ESC)
        else $error("ESC did not start an escape sequence");

    a_arg_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !w_is_flush && (r_phase == tcei_pkg::PH_POS_COL ||
        r_phase == tcei_pkg::PH_ATTR || r_phase == tcei_pkg::PH_FLASH ||
        r_phase == tcei_pkg::PH_XOR) |=> r_phase == tcei_pkg::PH_IDLE)
        else $error("final argument byte did not end the sequence");

endmodule

`default_nettype wire

// File: hdl/text_console_escape_interpreter_top.sv
// Top level: APB column register, escape parser core and a two-entry output buffer.
// Depends on tcei_pkg, tcei_if.sv and tcei_core.
//
// Takes one console word per clock while input ready is high: each accepted word updates
// cursor, attribute and escape state, and any screen command it causes is registered in
// the result register, or in the skid register while the output stalls, and shown on the
// output channel. The result register plus a skid register let input words keep flowing
// after the output stalls until a second command is buffered; outside reset, input ready
// drops only while both hold a word. screen_columns is written over APB at byte address 0
// (reset 80) and should only change while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module text_console_escape_interpreter_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    tcei_byte_if.sink                    i_byte,
    tcei_cmd_if.source                   o_cmd,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [tcei_pkg::PADDR_W-1:0]  paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [7:0]        r_screen_columns;
    logic              w_accept;
    logic              w_res_valid;
    tcei_pkg::t_result w_res;
    logic              r_out_valid, r_skid_valid;
    tcei_pkg::t_result r_out, r_skid;
    logic              w_out_fire;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_columns <= tcei_pkg::COLS_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == tcei_pkg::REG_COLS) begin
            r_screen_columns <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == tcei_pkg::REG_COLS) begin
            prdata = {24'd0, r_screen_columns};
        end
    end

    // input side
    assign i_byte.ready = i_rst_n && !r_skid_valid;
    assign w_accept     = i_byte.valid && i_byte.ready;

    tcei_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_kind           (i_byte.kind),
        .i_data           (i_byte.data),
        .i_screen_columns (r_screen_columns),
        .o_res_valid      (w_res_valid),
        .o_res            (w_res)
    );

    // output register with skid
    assign w_out_fire = r_out_valid && o_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || w_out_fire) begin
            r_out_valid <= w_accept && w_res_valid;
        end else if (w_accept && w_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || w_out_fire) begin
            r_out <= w_res;
        end else begin
            r_skid <= w_res;
        end
    end

    assign o_cmd.valid      = r_out_valid;
    assign o_cmd.command    = r_out.command;
    assign o_cmd.column     = r_out.column;
    assign o_cmd.row        = r_out.row;
    assign o_cmd.attribute  = r_out.attribute;
    assign o_cmd.value      = r_out.value;
    assign o_cmd.end_column = r_out.end_column;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output register");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && w_out_fire |=> r_out_valid && !r_skid_valid)
        else $error("skid word lost or duplicated on drain");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_res_valid |=> r_out_valid)
        else $error("accepted result word not buffered");

endmodule

`default_nettype wire
